// File: src/tpo2d_pkg.sv
// Shared widths, register indexes and orientation table for the triangle overlap block.
package tpo2d_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int DET_W      = PROD_W + 1;
   localparam int TOL_W      = 32;
   localparam int CMP_W      = (DET_W > TOL_W + 2) ? DET_W : TOL_W + 2;
   localparam int CSR_IDX_W  = 8;
   localparam int NPTS       = 6;
   localparam int NTRI       = 20;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INCLUDE_BOUNDARY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE        = CSR_IDX_W'(1);

   // Index of the sorted point triple (a < b < c) among all triples of six points
   function automatic int tri_id(input int a, input int b, input int c);
      int n;
      int r;
      n = 0;
      r = 0;
      for (int i = 0; i < NPTS; i++)
         for (int j = i + 1; j < NPTS; j++)
            for (int k = j + 1; k < NPTS; k++) begin
               if (i == a && j == b && k == c)
                  r = n;
               n = n + 1;
            end
      return r;
   endfunction

endpackage

// File: src/triangle_pair_overlap_2d.sv
// Top level: pipelined two-triangle planar overlap test with a decision tree on orientations.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  req_     | req_valid / req_stall | a0..a2, b0..b2 x/y coordinates
//  rsp_     | rsp_valid / rsp_stall | overlap
//  csr_     | csr_valid / csr_ready | csr_index, csr_wdata
//
// One pair enters per cycle unless a stalled result holds the pipeline; five register
// stages (input capture, differences, products, determinant compare, decision tree) carry
// each pair from its transfer edge to rsp_.
// All 20 point-triple orientations are formed in parallel, two multipliers each.
// Synchronous active-high reset clears the valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; req_stall follows it.
module triangle_pair_overlap_2d (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a0_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a0_y,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a1_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a1_y,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a2_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_a2_y,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b0_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b0_y,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b1_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b1_y,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b2_x,
   input  logic signed [tpo2d_pkg::COORD_BITS-1:0] req_b2_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_overlap,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tpo2d_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                            csr_wdata
);
   import tpo2d_pkg::*;

   logic                          incl_ff;
   logic [TOL_W-1:0]              tol_ff;
   logic                          adv;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [COORD_BITS-1:0]  px_ff [NPTS];
   logic signed [COORD_BITS-1:0]  py_ff [NPTS];
   logic signed [DIFF_W-1:0]      dux_ff [NTRI];
   logic signed [DIFF_W-1:0]      duy_ff [NTRI];
   logic signed [DIFF_W-1:0]      dvx_ff [NTRI];
   logic signed [DIFF_W-1:0]      dvy_ff [NTRI];
   logic signed [PROD_W-1:0]      m1_ff [NTRI];
   logic signed [PROD_W-1:0]      m2_ff [NTRI];
   logic [NTRI-1:0]               pp_in, pm_in, pp_ff, pm_ff;
   logic                          cwa_in, cwb_in, cwa_ff, cwb_ff;
   logic                          res_in, res_ff;
   logic signed [CMP_W-1:0]       det [NTRI];
   logic signed [CMP_W-1:0]       tol_s;

   // pos(u,v,w) from the flags of the sorted triple; odd permutations negate
   function automatic logic pos_t(input logic [NTRI-1:0] pp, input logic [NTRI-1:0] pm,
                                  input int u, input int v, input int w);
      logic r;
      r = 1'b0;
      for (int i = 0; i < NPTS; i++)
         for (int j = i + 1; j < NPTS; j++)
            for (int k = j + 1; k < NPTS; k++) begin
               if ((u == i && v == j && w == k) || (u == j && v == k && w == i) ||
                   (u == k && v == i && w == j))
                  r = pp[tri_id(i, j, k)];
               else if ((u == i && v == k && w == j) || (u == k && v == j && w == i) ||
                        (u == j && v == i && w == k))
                  r = pm[tri_id(i, j, k)];
            end
      return r;
   endfunction

   function automatic logic edge_t(input logic [NTRI-1:0] pp, input logic [NTRI-1:0] pm,
                                   input int p1, input int q1, input int r1,
                                   input int p2, input int r2);
      logic r;
      if (pos_t(pp, pm, r2, p2, q1)) begin
         if (pos_t(pp, pm, p1, p2, q1))
            r = pos_t(pp, pm, p1, q1, r2);
         else
            r = pos_t(pp, pm, q1, r1, p2) && pos_t(pp, pm, r1, p1, p2);
      end else if (pos_t(pp, pm, r2, p2, r1) && pos_t(pp, pm, p1, p2, r1))
         r = pos_t(pp, pm, p1, r1, r2) || pos_t(pp, pm, q1, r1, r2);
      else
         r = 1'b0;
      return r;
   endfunction

   // npos(u,v,w) equals pos(v,u,w)
   function automatic logic vert_t(input logic [NTRI-1:0] pp, input logic [NTRI-1:0] pm,
                                   input int p1, input int q1, input int r1,
                                   input int p2, input int q2, input int r2);
      logic r;
      if (pos_t(pp, pm, r2, p2, q1)) begin
         if (pos_t(pp, pm, q2, r2, q1)) begin
            if (pos_t(pp, pm, p1, p2, q1))
               r = pos_t(pp, pm, q2, p1, q1);
            else
               r = pos_t(pp, pm, p1, p2, r1) && pos_t(pp, pm, q1, r1, p2);
         end else
            r = pos_t(pp, pm, q2, p1, q1) && pos_t(pp, pm, q2, r2, r1) &&
                pos_t(pp, pm, q1, r1, q2);
      end else if (pos_t(pp, pm, r2, p2, r1)) begin
         if (pos_t(pp, pm, q1, r1, r2))
            r = pos_t(pp, pm, p1, p2, r1);
         else
            r = pos_t(pp, pm, q1, r1, q2) && pos_t(pp, pm, r2, r1, q2);
      end else
         r = 1'b0;
      return r;
   endfunction

   function automatic logic ccw_t(input logic [NTRI-1:0] pp, input logic [NTRI-1:0] pm,
                                  input int p1, input int q1, input int r1,
                                  input int p2, input int q2, input int r2);
      logic r;
      if (pos_t(pp, pm, p2, q2, p1)) begin
         if (pos_t(pp, pm, q2, r2, p1)) begin
            if (pos_t(pp, pm, r2, p2, p1))
               r = 1'b1;
            else
               r = edge_t(pp, pm, p1, q1, r1, p2, r2);
         end else if (pos_t(pp, pm, r2, p2, p1))
            r = edge_t(pp, pm, p1, q1, r1, r2, q2);
         else
            r = vert_t(pp, pm, p1, q1, r1, p2, q2, r2);
      end else if (pos_t(pp, pm, q2, r2, p1)) begin
         if (pos_t(pp, pm, r2, p2, p1))
            r = edge_t(pp, pm, p1, q1, r1, q2, p2);
         else
            r = vert_t(pp, pm, p1, q1, r1, q2, r2, p2);
      end else
         r = vert_t(pp, pm, p1, q1, r1, r2, p2, q2);
      return r;
   endfunction

   // Configuration registers, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         incl_ff <= 1'b1;
         tol_ff  <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_INCLUDE_BOUNDARY)
            incl_ff <= csr_wdata[0];
         else if (csr_index == REG_TOLERANCE)
            tol_ff <= csr_wdata[TOL_W-1:0];
      end
   end

   // Whole pipeline moves when the output slot is free or being taken
   assign adv       = !v5_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = v5_ff;
   assign rsp_overlap = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage 1: capture coordinates
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0] <= req_a0_x;  py_ff[0] <= req_a0_y;
         px_ff[1] <= req_a1_x;  py_ff[1] <= req_a1_y;
         px_ff[2] <= req_a2_x;  py_ff[2] <= req_a2_y;
         px_ff[3] <= req_b0_x;  py_ff[3] <= req_b0_y;
         px_ff[4] <= req_b1_x;  py_ff[4] <= req_b1_y;
         px_ff[5] <= req_b2_x;  py_ff[5] <= req_b2_y;
      end
   end

   // Stages 2 and 3: differences and products per sorted triple (u, v, w)
   for (genvar a = 0; a < NPTS; a++) begin : g_a
      for (genvar b = a + 1; b < NPTS; b++) begin : g_b
         for (genvar c = b + 1; c < NPTS; c++) begin : g_c
            localparam int ID = tri_id(a, b, c);
            always_ff @(posedge clock) begin
               if (adv) begin
                  dux_ff[ID] <= DIFF_W'(px_ff[a]) - DIFF_W'(px_ff[c]);
                  duy_ff[ID] <= DIFF_W'(py_ff[a]) - DIFF_W'(py_ff[c]);
                  dvx_ff[ID] <= DIFF_W'(px_ff[b]) - DIFF_W'(px_ff[c]);
                  dvy_ff[ID] <= DIFF_W'(py_ff[b]) - DIFF_W'(py_ff[c]);
                  m1_ff[ID]  <= PROD_W'(dux_ff[ID]) * PROD_W'(dvy_ff[ID]);
                  m2_ff[ID]  <= PROD_W'(duy_ff[ID]) * PROD_W'(dvx_ff[ID]);
               end
            end
         end
      end
   end

   // Stage 4: determinant and margin compares
   assign tol_s = signed'(CMP_W'(tol_ff));
   always_comb begin
      for (int i = 0; i < NTRI; i++) begin
         det[i] = CMP_W'(m1_ff[i]) - CMP_W'(m2_ff[i]);
         if (incl_ff) begin
            pp_in[i] = det[i] >= -tol_s;
            pm_in[i] = det[i] <= tol_s;
         end else begin
            pp_in[i] = det[i] > tol_s;
            pm_in[i] = det[i] < -tol_s;
         end
      end
      cwa_in = det[tri_id(0, 1, 2)] < -tol_s;
      cwb_in = det[tri_id(3, 4, 5)] < -tol_s;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff  <= pp_in;
         pm_ff  <= pm_in;
         cwa_ff <= cwa_in;
         cwb_ff <= cwb_in;
      end
   end

   // Stage 5: decision tree for the four winding cases
   always_comb begin
      case ({cwa_ff, cwb_ff})
         2'b11:   res_in = ccw_t(pp_ff, pm_ff, 0, 2, 1, 3, 5, 4);
         2'b10:   res_in = ccw_t(pp_ff, pm_ff, 0, 2, 1, 3, 4, 5);
         2'b01:   res_in = ccw_t(pp_ff, pm_ff, 0, 1, 2, 3, 5, 4);
         default: res_in = ccw_t(pp_ff, pm_ff, 0, 1, 2, 3, 4, 5);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv)
         res_ff <= res_in;
   end

endmodule

// File: test/triangle_pair_overlap_2d_tb.sv
// Self-checking testbench for the two-triangle planar overlap block.
`timescale 1ns / 100ps

module triangle_pair_overlap_2d_tb;
   import tpo2d_pkg::*;

   localparam int N_RANDOM    = 1420;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = 12;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef struct { longint x; longint y; } pt_type;
   typedef struct {
      coord_type c[12];
      int        want;   // -1: use the predictor
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_c[12];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_overlap;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the registers
   bit          mode_incl;
   longint      mode_tol;

   bit          overlap_q[$];
   int          mismatches = 0;
   int          n_checked = 0;
   int          n_sent = 0;
   int          n_hits = 0;
   int          cycles = 0;
   bit          hold_long = 1'b0;

   initial begin
      for (int i = 0; i < 12; i++)
         req_c[i] = '0;
   end

   triangle_pair_overlap_2d u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a0_x(req_c[0]), .req_a0_y(req_c[1]),
      .req_a1_x(req_c[2]), .req_a1_y(req_c[3]),
      .req_a2_x(req_c[4]), .req_a2_y(req_c[5]),
      .req_b0_x(req_c[6]), .req_b0_y(req_c[7]),
      .req_b1_x(req_c[8]), .req_b1_y(req_c[9]),
      .req_b2_x(req_c[10]), .req_b2_y(req_c[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_overlap(rsp_overlap),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint orient(pt_type u, pt_type v, pt_type w);
      return (u.x - w.x) * (v.y - w.y) - (u.y - w.y) * (v.x - w.x);
   endfunction

   function automatic bit is_pos(pt_type u, pt_type v, pt_type w);
      longint d;
      d = orient(u, v, w);
      return mode_incl ? (d >= -mode_tol) : (d > mode_tol);
   endfunction

   function automatic bit not_pos(pt_type u, pt_type v, pt_type w);
      longint d;
      d = orient(u, v, w);
      return mode_incl ? (d <= mode_tol) : (d < -mode_tol);
   endfunction

   function automatic bit edge_case(pt_type p1, pt_type q1, pt_type r1,
                                    pt_type p2, pt_type r2);
      if (is_pos(r2, p2, q1)) begin
         if (is_pos(p1, p2, q1))
            return is_pos(p1, q1, r2);
         return is_pos(q1, r1, p2) && is_pos(r1, p1, p2);
      end
      if (is_pos(r2, p2, r1) && is_pos(p1, p2, r1))
         return is_pos(p1, r1, r2) || is_pos(q1, r1, r2);
      return 1'b0;
   endfunction

   function automatic bit vertex_case(pt_type p1, pt_type q1, pt_type r1,
                                      pt_type p2, pt_type q2, pt_type r2);
      if (is_pos(r2, p2, q1)) begin
         if (not_pos(r2, q2, q1)) begin
            if (is_pos(p1, p2, q1))
               return not_pos(p1, q2, q1);
            return is_pos(p1, p2, r1) && is_pos(q1, r1, p2);
         end
         return not_pos(p1, q2, q1) && not_pos(r2, q2, r1) && is_pos(q1, r1, q2);
      end
      if (is_pos(r2, p2, r1)) begin
         if (is_pos(q1, r1, r2))
            return is_pos(p1, p2, r1);
         return is_pos(q1, r1, q2) && is_pos(r2, r1, q2);
      end
      return 1'b0;
   endfunction

   function automatic bit ccw_pair(pt_type p1, pt_type q1, pt_type r1,
                                   pt_type p2, pt_type q2, pt_type r2);
      if (is_pos(p2, q2, p1)) begin
         if (is_pos(q2, r2, p1)) begin
            if (is_pos(r2, p2, p1))
               return 1'b1;
            return edge_case(p1, q1, r1, p2, r2);
         end
         if (is_pos(r2, p2, p1))
            return edge_case(p1, q1, r1, r2, q2);
         return vertex_case(p1, q1, r1, p2, q2, r2);
      end
      if (is_pos(q2, r2, p1)) begin
         if (is_pos(r2, p2, p1))
            return edge_case(p1, q1, r1, q2, p2);
         return vertex_case(p1, q1, r1, q2, r2, p2);
      end
      return vertex_case(p1, q1, r1, r2, p2, q2);
   endfunction

   function automatic bit predict_overlap(coord_type c[12]);
      pt_type a[3];
      pt_type b[3];
      pt_type t;
      for (int i = 0; i < 3; i++) begin
         a[i].x = c[2*i];     a[i].y = c[2*i+1];
         b[i].x = c[6+2*i];   b[i].y = c[7+2*i];
      end
      // make both triangles counter-clockwise
      if (orient(a[0], a[1], a[2]) < -mode_tol) begin
         t = a[1]; a[1] = a[2]; a[2] = t;
      end
      if (orient(b[0], b[1], b[2]) < -mode_tol) begin
         t = b[1]; b[1] = b[2]; b[2] = t;
      end
      return ccw_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
   endfunction

   // ---------------- drivers ----------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_INCLUDE_BOUNDARY)
         mode_incl = val[0];
      else if (idx == REG_TOLERANCE)
         mode_tol = longint'(val);
   endtask

   // wait until every result is in, then let the pipe settle
   task automatic drain();
      while (overlap_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // one transfer; want >= 0 is a hand-typed expected value
   task automatic send_pair(coord_type c[12], int want, bit use_gap);
      bit p;
      int g;
      g = use_gap ? pick_gap() : 0;
      // valid drops during a gap so the last transfer is not taken again
      if (g != 0)
         req_valid <= 1'b0;
      repeat (g) @(posedge clock);
      p = predict_overlap(c);
      if (want >= 0 && p != want[0])
         $display("note: typed value %0d differs from predictor %0d", want, p);
      req_valid <= 1'b1;
      for (int i = 0; i < 12; i++)
         req_c[i] <= c[i];
      do @(posedge clock); while (req_stall);
      overlap_q.push_back(want >= 0 ? want[0] : p);
      n_sent++;
   endtask

   function automatic coord_type rnd_coord(int span);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return coord_type'($urandom);
      if (r == 1) return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      return coord_type'($signed($urandom_range(0, 2*span)) - span);
   endfunction

   function automatic void rnd_pair(output coord_type c[12]);
      int span;
      int kind;
      coord_type cx, cy;
      span = (1 << $urandom_range(2, 15)) - 1;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++)
         c[i] = rnd_coord(span);
      // near-touching variants: shared vertex, collinear, repeated points, near copies
      if (kind == 0) begin
         c[6] = c[2]; c[7] = c[3];
      end else if (kind == 1) begin
         cx = c[0]; cy = c[1];
         c[4] = coord_type'(2*c[2] - cx); c[5] = coord_type'(2*c[3] - cy);
      end else if (kind == 2) begin
         c[8] = c[6]; c[9] = c[7];
      end else if (kind == 3) begin
         for (int i = 0; i < 6; i++)
            c[6+i] = coord_type'(c[i] + $signed($urandom_range(0, 4)) - 2);
      end
   endfunction

   function automatic void mk(output coord_type c[12], input int v[12]);
      for (int i = 0; i < 12; i++)
         c[i] = coord_type'(v[i]);
   endfunction

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (!reset) begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver stall: random, plus one long hold-off
   initial begin
      int g;
      @(negedge reset);
      while (1) begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_long = 1'b0;
         end else begin
            g = pick_gap();
            if (g != 0 && $urandom_range(0, 2) == 0) begin
               rsp_stall <= 1'b1;
               repeat (g) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      bit exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (overlap_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result overlap=%0b", rsp_overlap);
         end else begin
            exp_v = overlap_q.pop_front();
            n_checked++;
            if (rsp_overlap) n_hits++;
            if (rsp_overlap !== exp_v) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch on result %0d: expected %0b got %0b",
                           n_checked, exp_v, rsp_overlap);
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   pair_row_type directed[$];

   initial begin
      coord_type c[12];
      pair_row_type row;
      mode_incl = 1'b1;
      mode_tol  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disjoint, nested, shared edge, touching vertex, extremes
      mk(row.c, '{0,0, 10,0, 0,10, 20,20, 30,20, 20,30});        row.want = 0;
      directed.push_back(row);
      mk(row.c, '{0,0, 100,0, 0,100, 1,1, 5,1, 1,5});            row.want = 1;
      directed.push_back(row);
      mk(row.c, '{0,0, 0,100, 100,0, 1,1, 1,5, 5,1});            row.want = 1;
      directed.push_back(row);
      mk(row.c, '{0,0, 10,0, 0,10, 10,0, 20,0, 10,10});          row.want = 1;
      directed.push_back(row);
      mk(row.c, '{0,0, 10,0, 0,10, 10,0, 0,10, 10,10});          row.want = 1;
      directed.push_back(row);
      mk(row.c, '{-32768,-32768, 32767,-32768, -32768,32767,
                  -32768,-32768, 32767,-32768, -32768,32767});  row.want = 1;
      directed.push_back(row);
      mk(row.c, '{-32768,-32768, 32767,-32768, -32768,32767,
                  32767,32767, 32767,32766, 32766,32767});      row.want = -1;
      directed.push_back(row);
      mk(row.c, '{32767,32767, 32767,32767, 32767,32767,
                  -32768,-32768, -32768,-32768, -32768,-32768}); row.want = -1;
      directed.push_back(row);
      mk(row.c, '{5,5, 5,5, 5,5, 5,5, 5,5, 5,5});               row.want = 1;
      directed.push_back(row);
      mk(row.c, '{0,0, 10,10, 20,20, 0,20, 20,0, 30,30});        row.want = -1;
      directed.push_back(row);
      mk(row.c, '{0,0, 10,0, 5,10, 0,5, 10,5, 5,-5});            row.want = 1;
      directed.push_back(row);
      mk(row.c, '{-1,-1, -1,-1, -1,-1, 0,0, 0,0, 0,0});          row.want = -1;
      directed.push_back(row);

      foreach (directed[i])
         send_pair(directed[i].c, directed[i].want, 1'b0);
      req_valid <= 1'b0;
      drain();

      // strict mode: touching cases must be rejected
      csr_write(REG_INCLUDE_BOUNDARY, 32'h0000_0000);
      foreach (directed[i])
         send_pair(directed[i].c, (i == 3 || i == 4) ? 0 : -1, 1'b1);
      req_valid <= 1'b0;
      drain();
      csr_write(8'd7, 32'hFFFF_FFFF);        // out-of-range index, ignored
      csr_write(REG_INCLUDE_BOUNDARY, 32'hFFFF_FFFE); // low bit only -> 0
      csr_write(REG_TOLERANCE, 32'hFFFF_FFFF);
      foreach (directed[i])
         send_pair(directed[i].c, -1, 1'b0);
      req_valid <= 1'b0;
      drain();

      // random phases across several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(REG_INCLUDE_BOUNDARY, 1); csr_write(REG_TOLERANCE, 0); end
            1: begin csr_write(REG_INCLUDE_BOUNDARY, 0); csr_write(REG_TOLERANCE, 0); end
            2: csr_write(REG_TOLERANCE, $urandom_range(1, 1000));
            3: begin csr_write(REG_INCLUDE_BOUNDARY, 1);
                     csr_write(REG_TOLERANCE, $urandom); end
            4: csr_write(REG_TOLERANCE, 32'hFFFF_FFFF);
            default: begin csr_write(REG_INCLUDE_BOUNDARY, $urandom);
                           csr_write(REG_TOLERANCE, $urandom_range(0, 50)); end
         endcase
         for (int k = 0; k < N_RANDOM / 6; k++) begin
            if (ph == 1 && k == 20) hold_long = 1'b1;
            rnd_pair(c);
            send_pair(c, -1, (ph == 1 && k < 120) ? 1'b0 : 1'b1);
         end
         req_valid <= 1'b0;
         drain();
      end

      $display("covered %0d pairs, %0d results checked, %0d overlapping",
               n_sent, n_checked, n_hits);
      $display("boundary modes both ways, tolerance from zero to full scale");
      if (mismatches == 0 && overlap_q.size() == 0)
         $display("TEST PASSED");
      else begin
         $display("%0d mismatches, %0d results missing", mismatches, overlap_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
